// ===== design/assert_macros.svh =====
// Assertion macros shared by the supervisor RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define CCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define CCS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/ccs_pkg.sv =====
// Shared types and constants for the capacitor charger supervisor.
// No dependencies; used by the config, step and top-level files.
package ccs_pkg;

  localparam int unsigned FlickBits = 8;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhCharge = 2'd1;
  localparam logic [1:0] PhReady  = 2'd2;
  localparam logic [1:0] PhFault  = 2'd3;

  localparam logic [CfgIdxBits-1:0] CfgReadyVoltage  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgDropVoltage   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgChargeTimeout = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgPulseOn       = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPulseOff      = 3'd4;

  localparam int unsigned ReadyVoltageRst  = 250;
  localparam int unsigned DropVoltageRst   = 230;
  localparam int unsigned ChargeTimeoutRst = 5000;
  localparam logic [FlickBits-1:0] PulseOnRst  = 8'd25;
  localparam logic [FlickBits-1:0] PulseOffRst = 8'd8;

  typedef struct packed {
    logic       drive;
    logic       ready;
    logic       dstop;
    logic [1:0] phase;
  } ccs_flags_t;

endpackage

// ===== design/ccs_cfg_regs.sv =====
// Configuration register file for the charger supervisor.
// Depends on ccs_pkg for register indexes and reset values.
module ccs_cfg_regs #(
  parameter int unsigned VOLTAGE_BITS = 10,
  parameter int unsigned TIMER_BITS   = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [ccs_pkg::CfgIdxBits-1:0]            cfg_index_i,
  input  logic [((VOLTAGE_BITS > TIMER_BITS) ? VOLTAGE_BITS : TIMER_BITS)-1:0] cfg_data_i,
  output logic [VOLTAGE_BITS-1:0]                   ready_voltage_o,
  output logic [VOLTAGE_BITS-1:0]                   drop_voltage_o,
  output logic [TIMER_BITS-1:0]                     charge_timeout_o,
  output logic [ccs_pkg::FlickBits-1:0]             pulse_on_o,
  output logic [ccs_pkg::FlickBits-1:0]             pulse_off_o
);

  logic [VOLTAGE_BITS-1:0]       ready_voltage_q, drop_voltage_q;
  logic [TIMER_BITS-1:0]         charge_timeout_q;
  logic [ccs_pkg::FlickBits-1:0] pulse_on_q, pulse_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_voltage_q  <= VOLTAGE_BITS'(ccs_pkg::ReadyVoltageRst);
      drop_voltage_q   <= VOLTAGE_BITS'(ccs_pkg::DropVoltageRst);
      charge_timeout_q <= TIMER_BITS'(ccs_pkg::ChargeTimeoutRst);
      pulse_on_q       <= ccs_pkg::PulseOnRst;
      pulse_off_q      <= ccs_pkg::PulseOffRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ccs_pkg::CfgReadyVoltage:  ready_voltage_q  <= cfg_data_i[VOLTAGE_BITS-1:0];
        ccs_pkg::CfgDropVoltage:   drop_voltage_q   <= cfg_data_i[VOLTAGE_BITS-1:0];
        ccs_pkg::CfgChargeTimeout: charge_timeout_q <= cfg_data_i[TIMER_BITS-1:0];
        ccs_pkg::CfgPulseOn:       pulse_on_q       <= cfg_data_i[ccs_pkg::FlickBits-1:0];
        ccs_pkg::CfgPulseOff:      pulse_off_q      <= cfg_data_i[ccs_pkg::FlickBits-1:0];
        default: ;
      endcase
    end
  end

  assign ready_voltage_o  = ready_voltage_q;
  assign drop_voltage_o   = drop_voltage_q;
  assign charge_timeout_o = charge_timeout_q;
  assign pulse_on_o       = pulse_on_q;
  assign pulse_off_o      = pulse_off_q;

endmodule

// ===== design/ccs_step.sv =====
// Next-state logic for one supervisor sample: phase decisions, then timer ticks.
// Depends on ccs_pkg for phase codes and the flag struct.
module ccs_step #(
  parameter int unsigned VOLTAGE_BITS = 10,
  parameter int unsigned TIMER_BITS   = 16
) (
  input  logic                          en_i,
  input  logic [VOLTAGE_BITS-1:0]       volt_i,
  input  logic                          tick_i,
  input  logic [VOLTAGE_BITS-1:0]       ready_voltage_i,
  input  logic [VOLTAGE_BITS-1:0]       drop_voltage_i,
  input  logic [TIMER_BITS-1:0]         charge_timeout_i,
  input  logic [ccs_pkg::FlickBits-1:0] pulse_on_i,
  input  logic [ccs_pkg::FlickBits-1:0] pulse_off_i,
  input  ccs_pkg::ccs_flags_t           flags_i,
  input  logic [TIMER_BITS-1:0]         charge_tmr_i,
  input  logic [ccs_pkg::FlickBits-1:0] flick_tmr_i,
  output ccs_pkg::ccs_flags_t           flags_o,
  output logic [TIMER_BITS-1:0]         charge_tmr_o,
  output logic [ccs_pkg::FlickBits-1:0] flick_tmr_o,
  output logic                          fault_event_o
);

  always_comb begin
    flags_o       = flags_i;
    charge_tmr_o  = charge_tmr_i;
    flick_tmr_o   = flick_tmr_i;
    fault_event_o = 1'b0;

    case (flags_i.phase)
      ccs_pkg::PhIdle: begin
        if (en_i) begin
          flags_o.dstop = 1'b1;
          flags_o.drive = 1'b1;
          charge_tmr_o  = '0;
          flags_o.phase = ccs_pkg::PhCharge;
        end else begin
          flags_o.drive = 1'b0;
          flags_o.ready = 1'b0;
        end
      end
      ccs_pkg::PhCharge: begin
        if (!en_i) begin
          flags_o.drive = 1'b0;
          flags_o.ready = 1'b0;
          flags_o.phase = ccs_pkg::PhIdle;
        end else if (volt_i > ready_voltage_i) begin
          flags_o.ready = 1'b1;
          flick_tmr_o   = '0;
          flags_o.phase = ccs_pkg::PhReady;
        end else if (charge_tmr_i > charge_timeout_i) begin
          flags_o.phase = ccs_pkg::PhFault;
          fault_event_o = 1'b1;
        end
      end
      ccs_pkg::PhReady: begin
        if (!en_i) begin
          flags_o.drive = 1'b0;
          flags_o.ready = 1'b0;
          flags_o.phase = ccs_pkg::PhIdle;
        end else if (volt_i < drop_voltage_i) begin
          flags_o.phase = ccs_pkg::PhFault;
          fault_event_o = 1'b1;
        end else if (flags_i.drive) begin
          if (flick_tmr_i > pulse_on_i) begin
            flags_o.drive = 1'b0;
            flick_tmr_o   = '0;
          end
        end else if (flick_tmr_i > pulse_off_i) begin
          flags_o.drive = 1'b1;
          flick_tmr_o   = '0;
        end
      end
      default: ;
    endcase

    // advance both timers after the decisions, holding at full scale
    if (tick_i) begin
      if (charge_tmr_o != '1) charge_tmr_o = charge_tmr_o + 1'b1;
      if (flick_tmr_o != '1) flick_tmr_o = flick_tmr_o + 1'b1;
    end
  end

endmodule

// ===== design/capacitor_charger_supervisor_unit.sv =====
// Capacitor charger supervisor: input register, step logic, result register.
// An input transfer fills the input register; its step result is then registered in the result register.
// Throughput: one sample per cycle while the result is not stalled; the combinational step logic sets the pace.
// The output register frees as its result transfers, so a stalled result holds one sample.
// Reset (rst_ni low, asynchronous) clears phase to idle, timers, flags and
// configuration to their defaults.
`include "assert_macros.svh"

module capacitor_charger_supervisor_unit #(
  parameter int unsigned VOLTAGE_BITS = 10,
  parameter int unsigned TIMER_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ccs_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [((VOLTAGE_BITS > TIMER_BITS) ? VOLTAGE_BITS : TIMER_BITS)-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               enable_request_i,
  input  logic [VOLTAGE_BITS-1:0]            bank_voltage_i,
  input  logic                               tick_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               charger_on_o,
  output logic                               discharge_stopped_o,
  output logic                               bank_ready_o,
  output logic                               fault_o,
  output logic                               fault_event_o,
  output logic [1:0]                         phase_o
);

  logic [VOLTAGE_BITS-1:0]       ready_voltage, drop_voltage;
  logic [TIMER_BITS-1:0]         charge_timeout;
  logic [ccs_pkg::FlickBits-1:0] pulse_on, pulse_off;

  ccs_cfg_regs #(
    .VOLTAGE_BITS(VOLTAGE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .ready_voltage_o (ready_voltage),
    .drop_voltage_o  (drop_voltage),
    .charge_timeout_o(charge_timeout),
    .pulse_on_o      (pulse_on),
    .pulse_off_o     (pulse_off)
  );

  // input stage
  logic                    in_valid_q, en_q, tick_q;
  logic [VOLTAGE_BITS-1:0] volt_q;
  logic                    advance;

  // supervisor state
  ccs_pkg::ccs_flags_t           flags_q, flags_d;
  logic [TIMER_BITS-1:0]         charge_tmr_q, charge_tmr_d;
  logic [ccs_pkg::FlickBits-1:0] flick_tmr_q, flick_tmr_d;
  logic                          event_d;

  // result stage
  logic                out_valid_q, event_q;
  ccs_pkg::ccs_flags_t res_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      en_q   <= enable_request_i;
      volt_q <= bank_voltage_i;
      tick_q <= tick_i;
    end
  end

  ccs_step #(
    .VOLTAGE_BITS(VOLTAGE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_step (
    .en_i            (en_q),
    .volt_i          (volt_q),
    .tick_i          (tick_q),
    .ready_voltage_i (ready_voltage),
    .drop_voltage_i  (drop_voltage),
    .charge_timeout_i(charge_timeout),
    .pulse_on_i      (pulse_on),
    .pulse_off_i     (pulse_off),
    .flags_i         (flags_q),
    .charge_tmr_i    (charge_tmr_q),
    .flick_tmr_i     (flick_tmr_q),
    .flags_o         (flags_d),
    .charge_tmr_o    (charge_tmr_d),
    .flick_tmr_o     (flick_tmr_d),
    .fault_event_o   (event_d)
  );

  // commit the step only when its result has somewhere to go
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '{drive: 1'b0, ready: 1'b0, dstop: 1'b0, phase: ccs_pkg::PhIdle};
      charge_tmr_q <= '0;
      flick_tmr_q  <= '0;
    end else if (advance) begin
      flags_q      <= flags_d;
      charge_tmr_q <= charge_tmr_d;
      flick_tmr_q  <= flick_tmr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q   <= flags_d;
      event_q <= event_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign charger_on_o        = res_q.drive;
  assign discharge_stopped_o = res_q.dstop;
  assign bank_ready_o        = res_q.ready;
  assign fault_o             = (res_q.phase == ccs_pkg::PhFault);
  assign fault_event_o       = event_q;
  assign phase_o             = res_q.phase;

  `CCS_ASSERT_NEXT(a_fault_sticky, clk_i, rst_ni, flags_q.phase == ccs_pkg::PhFault,
                   flags_q.phase == ccs_pkg::PhFault, "fault phase left without reset")
  `CCS_ASSERT_IMPL(a_event_in_fault, clk_i, rst_ni, out_valid_q && event_q,
                   res_q.phase == ccs_pkg::PhFault, "fault event outside fault phase")
  `CCS_ASSERT_NEVER(a_dstop_held, clk_i, rst_ni, $fell(flags_q.dstop),
                    "discharge stop flag cleared")
  `CCS_ASSERT_IMPL(a_ready_phase, clk_i, rst_ni, flags_q.ready,
                   flags_q.phase == ccs_pkg::PhReady || flags_q.phase == ccs_pkg::PhFault,
                   "ready flag set in idle or charging")

endmodule
